// ===== hw/rtl/base64_ascii85_decoder_unit_assert.svh =====
// Assertion macros shared by the decoder RTL; clocked on clk, disabled during arst_n low.
`ifndef BASE64_ASCII85_DECODER_UNIT_ASSERT_SVH
`define BASE64_ASCII85_DECODER_UNIT_ASSERT_SVH

// Condition must never hold.
`define B64A85_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Same-cycle implication.
`define B64A85_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define B64A85_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/b64a85_pkg.sv =====
// Shared types, constants and lookup functions of the base64 / ascii85 decoder.
package b64a85_pkg;

	// Default depth of the queue between front and back.
	localparam int CMD_DEPTH_DEF = 4;

	// Register indexes
	localparam logic REG_MODE = 1'b0;

	// Encoding modes
	localparam logic MODE_B64 = 1'b0;
	localparam logic MODE_A85 = 1'b1;

	// Symbol classes from the base64 table
	localparam logic [6:0] SYM_SKIP = 7'd64;
	localparam logic [6:0] SYM_PAD  = 7'd65;
	localparam logic [6:0] SYM_BAD  = 7'd66;

	// ascii85 constants
	localparam logic [7:0] A85_LOW  = 8'd33;
	localparam logic [7:0] A85_HIGH = 8'd117;
	localparam logic [6:0] A85_BASE = 7'd85;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_BAD_LEN  = 2'd2
	} status_t;

	// One transaction for the back end: up to four results from one word
	typedef struct packed {
		logic [31:0] word;     // bytes in order at [31:24], [23:16], ...
		logic [1:0]  nres_m1;  // number of results minus one
		logic        valid;    // results carry bytes
		status_t     status;
		logic        eol;      // final result closes the literal
		logic        a85_pad;  // word still needs 'u' padding
		logic [1:0]  pad_syms; // number of padding symbols, 1..3
	} cmd_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c == 8'd9) || (c == 8'd13) || (c == 8'd10);
	endfunction

	// Standard base64 alphabet value, or a symbol class
	function automatic logic [6:0] b64_value(input logic [7:0] c);
		logic [6:0] v;
		v = SYM_BAD;
		if (c >= 8'h41 && c <= 8'h5a)
			v = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7a)
			v = 7'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			v = 7'(c - 8'h30 + 8'd52);
		else if (c == 8'h2b)
			v = 7'd62;
		else if (c == 8'h2f)
			v = 7'd63;
		else if (c == 8'h3d)
			v = SYM_PAD;
		else if (is_space(c))
			v = SYM_SKIP;
		return v;
	endfunction

	// 85 to the power of the padding symbol count
	function automatic logic [19:0] a85_pow(input logic [1:0] p);
		logic [19:0] r;
		case (p)
			2'd1: r = 20'd85;
			2'd2: r = 20'd7225;
			2'd3: r = 20'd614125;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/b64a85_front.sv =====
// Front end: classifies characters, gathers symbol groups, issues result transactions.
module b64a85_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mode,
	input  logic               clear,
	input  logic               take,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               cmd_push,
	output b64a85_pkg::cmd_t   cmd
);

	logic [31:0] acc_q, nacc;
	logic [2:0]  cnt_q, ncnt;
	logic [1:0]  pad_q, npad;
	logic        err_q, nerr;
	logic        bad_char, grp, gen;
	logic [6:0]  bv;
	logic [7:0]  sym;
	logic [31:0] acc_x85;
	logic [1:0]  k;
	logic [2:0]  kp;
	logic        bad_len;

	assign bv      = b64a85_pkg::b64_value(char_code);
	assign sym     = char_code - b64a85_pkg::A85_LOW;
	assign acc_x85 = acc_q * 32'(b64a85_pkg::A85_BASE);

	// Character decode and group bookkeeping
	always_comb begin
		nacc     = acc_q;
		ncnt     = cnt_q;
		npad     = pad_q;
		nerr     = err_q;
		bad_char = 1'b0;
		grp      = 1'b0;
		gen      = 1'b0;
		k        = 2'd0;
		kp       = 3'd0;
		bad_len  = 1'b0;
		cmd          = '0;
		cmd.status   = b64a85_pkg::ST_OK;
		cmd.eol      = last_char;

		if (!err_q) begin
			if (mode == b64a85_pkg::MODE_B64) begin
				if (pad_q != 2'd0 && bv != b64a85_pkg::SYM_PAD) begin
					bad_char = 1'b1;
				end else if (bv == b64a85_pkg::SYM_PAD) begin
					if (pad_q >= 2'd2)
						bad_char = 1'b1;
					else
						npad = pad_q + 2'd1;
				end else if (bv < 7'd64) begin
					nacc = {8'd0, acc_q[17:0], bv[5:0]};
					ncnt = cnt_q + 3'd1;
					if (ncnt == 3'd4) begin
						grp         = 1'b1;
						cmd.word    = {nacc[23:0], 8'd0};
						cmd.nres_m1 = 2'd2;
						cmd.valid   = 1'b1;
						nacc        = '0;
						ncnt        = '0;
					end
				end else if (bv == b64a85_pkg::SYM_BAD) begin
					bad_char = 1'b1;
				end
			end else begin
				if (char_code >= b64a85_pkg::A85_LOW && char_code <= b64a85_pkg::A85_HIGH) begin
					nacc = acc_x85 + 32'(sym);
					ncnt = cnt_q + 3'd1;
					if (ncnt == 3'd5) begin
						grp         = 1'b1;
						cmd.word    = nacc;
						cmd.nres_m1 = 2'd3;
						cmd.valid   = 1'b1;
						nacc        = '0;
						ncnt        = '0;
					end
				end else if (!b64a85_pkg::is_space(char_code)) begin
					bad_char = 1'b1;
				end
			end

			if (bad_char) begin
				cmd         = '0;
				cmd.status  = b64a85_pkg::ST_BAD_CHAR;
				cmd.eol     = last_char;
				nerr        = 1'b1;
			end else if (last_char && !grp) begin
				// Flush of a partial group
				if (mode == b64a85_pkg::MODE_B64) begin
					k  = ncnt[1:0];
					kp = 3'(k) + 3'(npad);
					bad_len = (npad != 2'd0) ? (kp[1:0] != 2'd0) : (k == 2'd1);
					if (bad_len) begin
						cmd.status = b64a85_pkg::ST_BAD_LEN;
					end else if (k == 2'd2) begin
						cmd.word  = {nacc[11:4], 24'd0};
						cmd.valid = 1'b1;
					end else if (k == 2'd3) begin
						cmd.word    = {nacc[17:2], 16'd0};
						cmd.nres_m1 = 2'd1;
						cmd.valid   = 1'b1;
					end
				end else begin
					if (ncnt == 3'd1) begin
						cmd.status = b64a85_pkg::ST_BAD_LEN;
					end else if (ncnt >= 3'd2 && ncnt <= 3'd4) begin
						cmd.word     = nacc;
						cmd.valid    = 1'b1;
						cmd.a85_pad  = 1'b1;
						cmd.pad_syms = 2'(3'd5 - ncnt);
						cmd.nres_m1  = 2'(ncnt - 3'd2);
					end
				end
			end
			gen = bad_char | grp | last_char;
		end else begin
			// After an error only the terminator is produced
			gen = last_char;
		end

		if (last_char) begin
			nacc = '0;
			ncnt = '0;
			npad = '0;
			nerr = 1'b0;
		end
	end

	assign cmd_push = take & gen;

	// Literal state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			pad_q <= '0;
			err_q <= 1'b0;
		end else if (clear) begin
			acc_q <= '0;
			cnt_q <= '0;
			pad_q <= '0;
			err_q <= 1'b0;
		end else if (take) begin
			acc_q <= nacc;
			cnt_q <= ncnt;
			pad_q <= npad;
			err_q <= nerr;
		end
	end

endmodule

// ===== hw/rtl/b64a85_cmd_fifo.sv =====
// Transaction queue between the front and back ends.
`include "base64_ascii85_decoder_unit_assert.svh"

module b64a85_cmd_fifo #(
	parameter int DEPTH = b64a85_pkg::CMD_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  b64a85_pkg::cmd_t wdata,
	output logic             full,
	input  logic             rd,
	output b64a85_pkg::cmd_t rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64a85_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;
	assign rdata = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wdata;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	`B64A85_ASSERT_NEVER(a_fifo_overfill, count_q > CW'(DEPTH), "queue fill exceeds depth")
	`B64A85_ASSERT_NEXT(a_fifo_grow, do_wr && !do_rd, count_q == $past(count_q) + 1'b1, "write lost")
	`B64A85_ASSERT_NEXT(a_fifo_shrink, do_rd && !do_wr, count_q == $past(count_q) - 1'b1, "read lost")

endmodule

// ===== hw/rtl/b64a85_back.sv =====
// Back end: finishes ascii85 padding and emits one result per transaction slot.
`include "base64_ascii85_decoder_unit_assert.svh"

module b64a85_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64a85_pkg::cmd_t cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       data_byte,
	output logic             byte_valid,
	output logic             end_of_literal,
	output logic [1:0]       status
);

	b64a85_pkg::cmd_t cmd_s1, cmd_pd;
	logic             v_s1;
	logic [19:0]      pw;
	logic [31:0]      prod;
	logic [31:0]      padded;

	logic [31:0]         word_q;
	logic [1:0]          idx_q, last_q;
	logic                valid_q, eol_q, busy_q;
	b64a85_pkg::status_t st_q;
	logic                emit_done, em_free, s1_free;

	// Handoff between the queue, the padding stage and the emitter
	assign emit_done = busy_q & pop & (idx_q == last_q);
	assign em_free   = ~busy_q | emit_done;
	assign s1_free   = ~v_s1 | em_free;
	assign cmd_pop   = ~cmd_empty & s1_free;

	// ascii85 tail padding: w * 85^p + (85^p - 1)
	assign pw     = b64a85_pkg::a85_pow(cmd.pad_syms);
	assign prod   = cmd.word * {12'd0, pw};
	assign padded = prod + 32'(pw - 20'd1);

	// Padded word replaces the raw one for an ascii85 tail
	always_comb begin
		cmd_pd = cmd;
		if (cmd.a85_pad)
			cmd_pd.word = padded;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_s1 <= cmd_pd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s1_free)
			v_s1 <= cmd_pop;
	end

	// Emitter payload
	always_ff @(posedge clk) begin
		if (v_s1 && em_free) begin
			word_q  <= cmd_s1.word;
			last_q  <= cmd_s1.nres_m1;
			valid_q <= cmd_s1.valid;
			eol_q   <= cmd_s1.eol;
			st_q    <= cmd_s1.status;
		end
	end

	// Emitter control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (em_free) begin
			busy_q <= v_s1;
			idx_q  <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Result ports
	always_comb begin
		case (idx_q)
			2'd0: data_byte = word_q[31:24];
			2'd1: data_byte = word_q[23:16];
			2'd2: data_byte = word_q[15:8];
			2'd3: data_byte = word_q[7:0];
			default: data_byte = '0;
		endcase
	end

	assign empty          = ~busy_q;
	assign byte_valid     = valid_q;
	assign end_of_literal = eol_q & (idx_q == last_q);
	assign status         = st_q;

	`B64A85_ASSERT_IMPLY(a_idx_range, busy_q, idx_q <= last_q, "result index past count")
	`B64A85_ASSERT_IMPLY(a_nobyte_zero, busy_q && !valid_q, data_byte == 8'd0, "stray byte data")
	`B64A85_ASSERT_NEXT(a_step, busy_q && pop && !emit_done, busy_q && idx_q == $past(idx_q) + 2'd1, "result step lost")

endmodule

// ===== hw/rtl/base64_ascii85_decoder_unit.sv =====
// Top level of the streaming base64 / ascii85 literal decoder.
// Characters enter through the push/full queue interface, one per clock while not full; the
// front end classifies each character and, when a symbol group closes, a character is bad or
// the literal ends, places one transaction of up to four results in a command queue
// (CMD_DEPTH entries). The back end pads an ascii85 tail (one 32x20 multiply) as it leaves
// the queue, registers it in its padding stage and then emits one result per clock on the
// empty/pop side while pop is high. A character is taken only while the command queue is not
// full. encoding_mode sits at APB address 0; writing it restarts the literal.
module base64_ascii85_decoder_unit #(
	parameter int CMD_DEPTH = b64a85_pkg::CMD_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// character input
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	// result output
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  data_byte,
	output logic        byte_valid,
	output logic        end_of_literal,
	output logic [1:0]  status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic             mode_q;
	logic             cfg_wr;
	logic             take;
	logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
	b64a85_pkg::cmd_t cmd_in, cmd_out;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == b64a85_pkg::REG_MODE);
	assign prdata = (paddr[2] == b64a85_pkg::REG_MODE) ? {31'd0, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= b64a85_pkg::MODE_B64;
		else if (cfg_wr)
			mode_q <= pwdata[0];
	end

	assign full = cmd_full;
	assign take = push & ~cmd_full;

	b64a85_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.clear     (cfg_wr),
		.take      (take),
		.char_code (char_code),
		.last_char (last_char),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	b64a85_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	b64a85_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd_out),
		.cmd_empty      (cmd_empty),
		.cmd_pop        (cmd_pop),
		.empty          (empty),
		.pop            (pop),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_literal (end_of_literal),
		.status         (status)
	);

endmodule
